// ----- hw/rtl/dma4_pkg.sv -----
`default_nettype none

package dma4_pkg;

  // Build constants
  localparam int NUM_CHANNELS = 4;   // 1 to 4
  localparam int ADDR_BITS    = 32;  // 16 to 32
  localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EN_VEC_W     = 8;   // width of the enable vector
  localparam int WIDE_CHANNEL = 3;   // channel with the 16-bit count

  // Control word bit positions
  localparam int DMODE_LSB = 21;
  localparam int SMODE_LSB = 23;
  localparam int REPEAT_BIT = 25;
  localparam int WORD_BIT   = 26;
  localparam int START_LSB  = 28;
  localparam int ENABLE_BIT = 31;

  // Address step modes
  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  localparam logic [1:0] START_NOW = 2'd0;

  typedef logic [CH_IDX_BITS-1:0] ch_idx_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [16:0]            count_t;

  typedef enum logic [2:0] {
    CMD_SRC   = 3'd0,
    CMD_DST   = 3'd1,
    CMD_CTRL  = 3'd2,
    CMD_EVENT = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  channel;
    logic [31:0] wdata;
    logic [1:0]  timing;
  } item_t;

  typedef struct packed {
    logic [1:0]  xfer_channel;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        word_size;
    logic        last_unit;
    logic [3:0]  enabled_mask;
  } result_t;

  // Block length from a control word; zero count means the full range.
  function automatic count_t block_units(input logic [31:0] cw, input logic wide);
    count_t n;
    if (wide) begin
      n = {1'b0, cw[15:0]};
      if (cw[15:0] == 16'd0) n = 17'h10000;
    end else begin
      n = {3'b000, cw[13:0]};
      if (cw[13:0] == 14'd0) n = 17'h04000;
    end
    return n;
  endfunction

  function automatic addr_t step_addr(input addr_t a, input logic [1:0] mode,
                                      input logic word);
    addr_t unit;
    addr_t r;
    unit = word ? addr_t'(4) : addr_t'(2);
    case (mode)
      MODE_FIXED: r = a;
      MODE_DEC:   r = a - unit;
      default:    r = a + unit;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dma4_core.sv -----
`default_nettype none

module dma4_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire dma4_pkg::item_t  item,
  output logic                  res_valid,
  output dma4_pkg::result_t     res
);

  dma4_pkg::addr_t  src_setting  [dma4_pkg::NUM_CHANNELS];
  dma4_pkg::addr_t  dst_setting  [dma4_pkg::NUM_CHANNELS];
  logic [31:0]      control_word [dma4_pkg::NUM_CHANNELS];
  dma4_pkg::addr_t  src_work     [dma4_pkg::NUM_CHANNELS];
  dma4_pkg::addr_t  dst_work     [dma4_pkg::NUM_CHANNELS];
  dma4_pkg::count_t units_left   [dma4_pkg::NUM_CHANNELS];
  logic [dma4_pkg::NUM_CHANNELS-1:0] pending_mask;

  dma4_pkg::ch_idx_t wr_idx;
  logic              wr_ok;
  logic              wr_wide;
  logic              was_on;

  dma4_pkg::ch_idx_t sel;
  logic              found;
  logic              sel_wide;
  logic [31:0]       cw_sel;
  logic [1:0]        smode;
  logic [1:0]        dmode;
  logic              word;
  logic              last;
  logic              rearm;
  logic              is_tick;
  dma4_pkg::addr_t   src_step;
  dma4_pkg::addr_t   dst_step;
  logic [dma4_pkg::EN_VEC_W-1:0] en_after;

  assign wr_idx  = dma4_pkg::ch_idx_t'(item.channel);
  assign wr_ok   = 32'(item.channel) < 32'(dma4_pkg::NUM_CHANNELS);
  assign wr_wide = item.channel == 2'(dma4_pkg::WIDE_CHANNEL);
  assign was_on  = control_word[wr_idx][dma4_pkg::ENABLE_BIT];

  // Lowest pending channel wins.
  always_comb begin
    found    = 1'b0;
    sel      = '0;
    sel_wide = 1'b0;
    for (int i = 0; i < dma4_pkg::NUM_CHANNELS; i++) begin
      if (!found && pending_mask[i]) begin
        found    = 1'b1;
        sel      = dma4_pkg::ch_idx_t'(i);
        sel_wide = (i == dma4_pkg::WIDE_CHANNEL);
      end
    end
  end

  assign is_tick  = item.cmd == dma4_pkg::CMD_TICK;
  assign cw_sel   = control_word[sel];
  assign smode    = cw_sel[dma4_pkg::SMODE_LSB +: 2];
  assign dmode    = cw_sel[dma4_pkg::DMODE_LSB +: 2];
  assign word     = cw_sel[dma4_pkg::WORD_BIT];
  assign last     = units_left[sel] <= 17'd1;
  assign rearm    = cw_sel[dma4_pkg::REPEAT_BIT] &&
                    (cw_sel[dma4_pkg::START_LSB +: 2] != dma4_pkg::START_NOW);
  assign src_step = dma4_pkg::step_addr(src_work[sel], smode, word);
  assign dst_step = dma4_pkg::step_addr(dst_work[sel], dmode, word);

  // Enable bits as they stand after this tick.
  always_comb begin
    en_after = '0;
    for (int i = 0; i < dma4_pkg::NUM_CHANNELS; i++) begin
      en_after[i] = control_word[i][dma4_pkg::ENABLE_BIT];
    end
    if (found && last && !rearm) en_after[sel] = 1'b0;
  end

  assign res_valid        = is_tick && found;
  assign res.xfer_channel = 2'(sel);
  assign res.src_addr     = 32'(src_work[sel]);
  assign res.dst_addr     = 32'(dst_work[sel]);
  assign res.word_size    = word;
  assign res.last_unit    = last;
  assign res.enabled_mask = en_after[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dma4_pkg::NUM_CHANNELS; i++) begin
        src_setting[i]  <= '0;
        dst_setting[i]  <= '0;
        control_word[i] <= '0;
        src_work[i]     <= '0;
        dst_work[i]     <= '0;
        units_left[i]   <= '0;
      end
      pending_mask <= '0;
    end else if (fire) begin
      case (item.cmd)
        dma4_pkg::CMD_SRC: begin
          if (wr_ok) src_setting[wr_idx] <= dma4_pkg::addr_t'(item.wdata);
        end
        dma4_pkg::CMD_DST: begin
          if (wr_ok) dst_setting[wr_idx] <= dma4_pkg::addr_t'(item.wdata);
        end
        dma4_pkg::CMD_CTRL: begin
          if (wr_ok) begin
            control_word[wr_idx] <= item.wdata;
            if (!item.wdata[dma4_pkg::ENABLE_BIT]) begin
              pending_mask[wr_idx] <= 1'b0;
            end else if (!was_on) begin
              src_work[wr_idx]   <= src_setting[wr_idx];
              dst_work[wr_idx]   <= dst_setting[wr_idx];
              units_left[wr_idx] <= dma4_pkg::block_units(item.wdata, wr_wide);
              if (item.wdata[dma4_pkg::START_LSB +: 2] == dma4_pkg::START_NOW) begin
                pending_mask[wr_idx] <= 1'b1;
              end
            end
          end
        end
        dma4_pkg::CMD_EVENT: begin
          if (item.timing != dma4_pkg::START_NOW) begin
            for (int i = 0; i < dma4_pkg::NUM_CHANNELS; i++) begin
              if (control_word[i][dma4_pkg::ENABLE_BIT] &&
                  control_word[i][dma4_pkg::START_LSB +: 2] == item.timing) begin
                pending_mask[i] <= 1'b1;
              end
            end
          end
        end
        dma4_pkg::CMD_TICK: begin
          if (found) begin
            src_work[sel] <= src_step;
            // Reload the destination at block end of a repeating reload channel.
            if (last && rearm && dmode == dma4_pkg::MODE_RELOAD) begin
              dst_work[sel] <= dst_setting[sel];
            end else begin
              dst_work[sel] <= dst_step;
            end
            if (last) begin
              pending_mask[sel] <= 1'b0;
              if (rearm) begin
                units_left[sel] <= dma4_pkg::block_units(cw_sel, sel_wide);
              end else begin
                units_left[sel] <= '0;
                control_word[sel][dma4_pkg::ENABLE_BIT] <= 1'b0;
              end
            end else begin
              units_left[sel] <= units_left[sel] - 17'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dma4_out_reg.sv -----
`default_nettype none

module dma4_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire dma4_pkg::result_t res,
  input  wire logic              stall,
  output logic                   valid,
  output dma4_pkg::result_t      res_q,
  output logic                   free
);

  logic valid_next;

  assign free       = !valid || !stall;
  assign valid_next = load || (valid && stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload holds while stalled; load only when the slot is free.
  always_ff @(posedge clk) begin
    if (load) res_q <= res;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/four_channel_dma_engine.sv -----
// Path: a taken tick is held in the input register, executes in the core once the result slot is free,
// and its transfer is then offered from the result register.
// Throughput: one word per cycle unless a stalled result blocks it; each tick or write is one word.
// The only back-pressure is the result register: input stalls while a result waits and is stalled.
// Reset (rst, synchronous, active high) clears all channel registers, counts and pending requests,
// and empties both the input and the result register.
`default_nettype none

module four_channel_dma_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [1:0]  channel,
  input  wire logic [31:0] wdata,
  input  wire logic [1:0]  timing,
  // transfer channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       xfer_channel,
  output logic [31:0]      src_addr,
  output logic [31:0]      dst_addr,
  output logic             word_size,
  output logic             last_unit,
  output logic [3:0]       enabled_mask
);

  logic              item_valid;
  dma4_pkg::item_t   item;
  logic              out_free;
  logic              fire;
  logic              res_valid;
  dma4_pkg::result_t res;
  dma4_pkg::result_t res_q;

  // The held word executes as soon as the result slot can take whatever it makes.
  // Commands that make no result still wait for the slot; this keeps state updates
  // strictly in order with the transfers they follow.
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  // Input register: load a new word whenever the held one executes or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd     <= dma4_pkg::cmd_t'(cmd);
      item.channel <= channel;
      item.wdata   <= wdata;
      item.timing  <= timing;
    end
  end

  // Channel registers, priority pick and address step.
  dma4_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: advance on a served tick, hold while stalled.
  dma4_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (fire && res_valid),
    .res   (res),
    .stall (out_stall),
    .valid (out_valid),
    .res_q (res_q),
    .free  (out_free)
  );

  assign xfer_channel = res_q.xfer_channel;
  assign src_addr     = res_q.src_addr;
  assign dst_addr     = res_q.dst_addr;
  assign word_size    = res_q.word_size;
  assign last_unit    = res_q.last_unit;
  assign enabled_mask = res_q.enabled_mask;

endmodule

`default_nettype wire

// ----- hw/rtl/dma4_checker.sv -----
`default_nettype none

module dma4_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  cmd,
  input wire logic [1:0]  channel,
  input wire logic [31:0] wdata,
  input wire logic [1:0]  timing,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  xfer_channel,
  input wire logic [31:0] src_addr,
  input wire logic [31:0] dst_addr,
  input wire logic        word_size,
  input wire logic        last_unit,
  input wire logic [3:0]  enabled_mask
);

  // A stalled transfer holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(src_addr) && $stable(dst_addr) &&
                               $stable(xfer_channel) && $stable(last_unit) &&
                               $stable(word_size))
    else $error("transfer word changed while stalled");

  // A stalled command word holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(channel) &&
                             $stable(wdata) && $stable(timing))
    else $error("command word changed while stalled");

  // Input stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result slot free");

  // A unit that does not end the block leaves its channel enabled.
  a_still_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_unit |-> enabled_mask[xfer_channel])
    else $error("channel disabled before its last unit");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind four_channel_dma_engine dma4_checker u_dma4_checker (.*);

`default_nettype wire

// ----- tb/sv/dma4_scoreboard_pkg.sv -----
package dma4_scoreboard_pkg;

  import dma4_pkg::*;

  localparam count_t FULL_WIDE_BLOCK   = 17'h10000;
  localparam count_t FULL_NARROW_BLOCK = 17'h04000;

  // Tracks channel state, works out the transfer each tick should produce
  // and matches the transfers that come out of the engine in order.
  class transfer_scoreboard;
    logic [31:0] src_cfg [NUM_CHANNELS];
    logic [31:0] dst_cfg [NUM_CHANNELS];
    logic [31:0] ctrl [NUM_CHANNELS];
    addr_t src_cur [NUM_CHANNELS];
    addr_t dst_cur [NUM_CHANNELS];
    count_t remaining [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] pending;
    result_t transfers_due [$];
    int errors;
    int checked;
    int blocks_done;
    int reloads;

    function new();
      int k;
      for (k = 0; k < NUM_CHANNELS; k++) begin
        src_cfg[k] = '0;
        dst_cfg[k] = '0;
        ctrl[k] = '0;
        src_cur[k] = '0;
        dst_cur[k] = '0;
        remaining[k] = '0;
      end
      pending = '0;
      errors = 0;
      checked = 0;
      blocks_done = 0;
      reloads = 0;
    endfunction

    function count_t block_length(int ch);
      count_t n;
      if (ch == WIDE_CHANNEL) begin
        n = {1'b0, ctrl[ch][15:0]};
        if (ctrl[ch][15:0] == 16'd0) n = FULL_WIDE_BLOCK;
      end else begin
        n = {3'b000, ctrl[ch][13:0]};
        if (ctrl[ch][13:0] == 14'd0) n = FULL_NARROW_BLOCK;
      end
      return n;
    endfunction

    function addr_t stepped(addr_t a, logic [1:0] mode, addr_t unit);
      if (mode == MODE_FIXED) return a;
      if (mode == MODE_DEC) return a - unit;
      return a + unit;
    endfunction

    // Serve the lowest pending channel, if any.
    function void serve_tick();
      int k;
      int pick;
      logic [31:0] cw;
      logic [1:0] smode;
      logic [1:0] dmode;
      addr_t unit;
      logic fin;
      result_t r;
      pick = -1;
      for (k = NUM_CHANNELS - 1; k >= 0; k--) begin
        if (pending[k]) pick = k;
      end
      if (pick < 0) return;
      cw = ctrl[pick];
      unit = cw[WORD_BIT] ? addr_t'(4) : addr_t'(2);
      smode = cw[SMODE_LSB +: 2];
      dmode = cw[DMODE_LSB +: 2];
      fin = remaining[pick] <= 17'd1;
      r.xfer_channel = 2'(pick);
      r.src_addr = src_cur[pick];
      r.dst_addr = dst_cur[pick];
      r.word_size = cw[WORD_BIT];
      r.last_unit = fin;
      src_cur[pick] = stepped(src_cur[pick], smode, unit);
      dst_cur[pick] = stepped(dst_cur[pick], dmode, unit);
      if (fin) begin
        pending[pick] = 1'b0;
        blocks_done++;
        if (cw[REPEAT_BIT] && cw[START_LSB +: 2] != START_NOW) begin
          remaining[pick] = block_length(pick);
          if (dmode == MODE_RELOAD) dst_cur[pick] = dst_cfg[pick];
          reloads++;
        end else begin
          remaining[pick] = '0;
          ctrl[pick][ENABLE_BIT] = 1'b0;
        end
      end else begin
        remaining[pick] = remaining[pick] - 17'd1;
      end
      r.enabled_mask = '0;
      for (k = 0; k < NUM_CHANNELS; k++) r.enabled_mask[k] = ctrl[k][ENABLE_BIT];
      transfers_due.push_back(r);
    endfunction

    function void note_word(logic [2:0] c, logic [1:0] ch, logic [31:0] wd, logic [1:0] tm);
      logic was_on;
      int k;
      case (c)
        CMD_SRC: src_cfg[ch] = addr_t'(wd);
        CMD_DST: dst_cfg[ch] = addr_t'(wd);
        CMD_CTRL: begin
          was_on = ctrl[ch][ENABLE_BIT];
          ctrl[ch] = wd;
          if (!wd[ENABLE_BIT]) begin
            pending[ch] = 1'b0;
          end else if (!was_on) begin
            src_cur[ch] = src_cfg[ch];
            dst_cur[ch] = dst_cfg[ch];
            remaining[ch] = block_length(ch);
            if (wd[START_LSB +: 2] == START_NOW) pending[ch] = 1'b1;
          end
        end
        CMD_EVENT: begin
          if (tm != START_NOW) begin
            for (k = 0; k < NUM_CHANNELS; k++) begin
              if (ctrl[k][ENABLE_BIT] && ctrl[k][START_LSB +: 2] == tm) pending[k] = 1'b1;
            end
          end
        end
        CMD_TICK: serve_tick();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_transfer(result_t got);
      result_t want;
      if (transfers_due.size() == 0) begin
        $error("transfer with none expected: channel %0d src %h dst %h",
               got.xfer_channel, got.src_addr, got.dst_addr);
        errors++;
        return;
      end
      want = transfers_due.pop_front();
      checked++;
      compare_field("xfer_channel", 32'(want.xfer_channel), 32'(got.xfer_channel));
      compare_field("src_addr", want.src_addr, got.src_addr);
      compare_field("dst_addr", want.dst_addr, got.dst_addr);
      compare_field("word_size", 32'(want.word_size), 32'(got.word_size));
      compare_field("last_unit", 32'(want.last_unit), 32'(got.last_unit));
      compare_field("enabled_mask", 32'(want.enabled_mask), 32'(got.enabled_mask));
    endfunction

    function int outstanding();
      return transfers_due.size();
    endfunction

    function void close();
      if (transfers_due.size() != 0) begin
        $error("%0d expected transfers never arrived", transfers_due.size());
        errors += transfers_due.size();
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb.sv -----
module tb;

  import dma4_pkg::*;
  import dma4_scoreboard_pkg::*;

  // Start conditions carried by a timing event, and a command code the engine ignores.
  localparam logic [1:0] START_VBLANK  = 2'd1;
  localparam logic [1:0] START_HBLANK  = 2'd2;
  localparam logic [1:0] START_SPECIAL = 2'd3;
  localparam logic [2:0] CMD_SPARE     = 3'd7;

  localparam int ITEMS_TARGET   = 1700;
  localparam int CALM_FROM      = 1450;  // no idling on either side past this word
  localparam int PAUSE_EVERY    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = 3'd0;
  logic [1:0]  channel = 2'd0;
  logic [31:0] wdata = 32'd0;
  logic [1:0]  timing = 2'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  xfer_channel;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic        word_size;
  logic        last_unit;
  logic [3:0]  enabled_mask;

  transfer_scoreboard sb;
  result_t seen_xfer;
  logic    calm = 1'b0;
  int      words_sent = 0;
  int      next_pause = PAUSE_EVERY;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  int      pick;
  logic [31:0] cw;

  always #5 clk = ~clk;

  four_channel_dma_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .channel      (channel),
    .wdata        (wdata),
    .timing       (timing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .xfer_channel (xfer_channel),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .word_size    (word_size),
    .last_unit    (last_unit),
    .enabled_mask (enabled_mask)
  );

  // Sample both handshakes at the rising edge. A word taken here updates the
  // channel model at once; its transfer comes out only after the input and result registers.
  // The watchdog counts edges at which neither side moves a word.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        sb.note_word(cmd, channel, wdata, timing);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        seen_xfer.xfer_channel = xfer_channel;
        seen_xfer.src_addr = src_addr;
        seen_xfer.dst_addr = dst_addr;
        seen_xfer.word_size = word_size;
        seen_xfer.last_unit = last_unit;
        seen_xfer.enabled_mask = enabled_mask;
        sb.check_transfer(seen_xfer);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure: random stall bursts, none once calm.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall = 1'b0;
      if (!rst && !calm && $urandom_range(4, 0) == 0) stall_left = $urandom_range(6, 1);
    end
  end

  // Drive one word at the falling edge and hold it until the engine takes it.
  // Before the word, now and then drop valid for a short burst.
  task automatic send_word(input logic [2:0] c, input logic [1:0] ch,
                           input logic [31:0] wd, input logic [1:0] tm);
    if (!calm && $urandom_range(6, 0) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    cmd = c;
    channel = ch;
    wdata = wd;
    timing = tm;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 2'($urandom()), $urandom(), 2'($urandom()));
  endtask

  // Hold off the sender until every predicted transfer has come out.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Random address, now and then close to either end of the space so steps wrap.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(7, 0))
      0: a[31:4] = '1;
      1: a[31:4] = '0;
      default: ;
    endcase
    return a;
  endfunction

  // Enabled control word with random flags; bits above a narrow count stay random.
  function automatic logic [31:0] armed_ctrl(input logic [1:0] ch, input logic [15:0] units);
    logic [31:0] w;
    w = $urandom();
    w[ENABLE_BIT] = 1'b1;
    if (ch == WIDE_CHANNEL) w[15:0] = units;
    else w[13:0] = units[13:0];
    return w;
  endfunction

  // Well-formed block: stop, set addresses, arm, fire the start event if timed,
  // then tick it through. Sometimes arm a second channel to contend for ticks.
  task automatic run_block(input logic [1:0] ch);
    logic [31:0] w;
    logic [31:0] w_mate;
    logic [1:0]  mate;
    logic [15:0] units;
    logic [15:0] units_mate;
    int          ticks;
    w = $urandom();
    w[ENABLE_BIT] = 1'b0;
    send_word(CMD_CTRL, ch, w, 2'($urandom()));
    send_word(CMD_SRC, ch, pick_addr(), 2'($urandom()));
    send_word(CMD_DST, ch, pick_addr(), 2'($urandom()));
    units = 16'($urandom_range(6, 1));
    w = armed_ctrl(ch, units);
    send_word(CMD_CTRL, ch, w, 2'($urandom()));
    ticks = units;
    mate = 2'($urandom());
    if (mate != ch && $urandom_range(3, 0) == 0) begin
      send_word(CMD_CTRL, mate, 32'd0, 2'($urandom()));
      units_mate = 16'($urandom_range(4, 1));
      w_mate = armed_ctrl(mate, units_mate);
      send_word(CMD_CTRL, mate, w_mate, 2'($urandom()));
      if (w_mate[START_LSB +: 2] != START_NOW)
        send_word(CMD_EVENT, 2'($urandom()), $urandom(), w_mate[START_LSB +: 2]);
      ticks = ticks + units_mate;
    end
    if (w[START_LSB +: 2] != START_NOW)
      send_word(CMD_EVENT, 2'($urandom()), $urandom(), w[START_LSB +: 2]);
    repeat (ticks + $urandom_range(2, 0)) begin
      if ($urandom_range(9, 0) == 0)
        send_word(CMD_EVENT, 2'($urandom()), $urandom(), 2'($urandom()));
      send_tick();
    end
    // A repeating timed channel stays armed: run a second block.
    if (w[REPEAT_BIT] && w[START_LSB +: 2] != START_NOW) begin
      send_word(CMD_EVENT, 2'($urandom()), $urandom(), w[START_LSB +: 2]);
      repeat (units) send_tick();
    end
  endtask

  // Broken block: long or odd counts, rewrite while running, stop midway.
  task automatic run_broken(input logic [1:0] ch);
    logic [31:0] w;
    int          k;
    if ($urandom_range(2, 0) == 0) begin
      for (k = 0; k < NUM_CHANNELS; k++) send_word(CMD_CTRL, 2'(k), 32'd0, 2'($urandom()));
    end
    send_word(CMD_CTRL, ch, 32'd0, 2'($urandom()));
    send_word(CMD_SRC, ch, pick_addr(), 2'($urandom()));
    send_word(CMD_DST, ch, pick_addr(), 2'($urandom()));
    w = armed_ctrl(ch, ($urandom_range(1, 0) == 0) ? 16'd0 : 16'($urandom()));
    if ($urandom_range(1, 0) == 0) w[START_LSB +: 2] = START_NOW;
    send_word(CMD_CTRL, ch, w, 2'($urandom()));
    if (w[START_LSB +: 2] != START_NOW)
      send_word(CMD_EVENT, 2'($urandom()), $urandom(), 2'($urandom()));
    repeat ($urandom_range(6, 1)) send_tick();
    send_word(CMD_CTRL, ch, armed_ctrl(ch, 16'($urandom())), 2'($urandom()));
    repeat ($urandom_range(4, 1)) send_tick();
    w = $urandom();
    w[ENABLE_BIT] = 1'b0;
    send_word(CMD_CTRL, ch, w, 2'($urandom()));
    send_tick();
  endtask

  // Noise: any command code, any field, ticks mixed in.
  task automatic run_noise();
    logic [2:0]  c;
    logic [31:0] w;
    repeat ($urandom_range(5, 1)) begin
      c = 3'($urandom());
      w = $urandom();
      if (c == CMD_CTRL && $urandom_range(3, 0) != 0) w[15:0] = 16'($urandom_range(8, 1));
      send_word(c, 2'($urandom()), w, 2'($urandom()));
      if ($urandom_range(1, 0) == 0) send_tick();
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Idle engine: tick with nothing pending, event of timing zero, unused code.
    send_word(CMD_TICK, 2'd0, 32'd0, START_NOW);
    send_word(CMD_EVENT, 2'd0, 32'd0, START_NOW);
    send_word(CMD_SPARE, 2'd3, 32'hFFFF_FFFF, START_SPECIAL);

    // Channel 0: source climbs past the top, destination drops below zero;
    // count bits above the narrow field are ignored.
    send_word(CMD_SRC, 2'd0, 32'hFFFF_FFFE, START_NOW);
    send_word(CMD_DST, 2'd0, 32'h0000_0000, START_NOW);
    cw = 32'd0;
    cw[ENABLE_BIT] = 1'b1;
    cw[SMODE_LSB +: 2] = MODE_INC;
    cw[DMODE_LSB +: 2] = MODE_DEC;
    cw[15:0] = 16'hC002;
    send_word(CMD_CTRL, 2'd0, cw, START_NOW);
    send_tick();
    send_tick();

    // Channel 3: repeating vblank block of words, fixed source, reloading destination.
    send_word(CMD_SRC, 2'd3, 32'h0300_0000, START_NOW);
    send_word(CMD_DST, 2'd3, 32'h0600_0010, START_NOW);
    cw = 32'd0;
    cw[ENABLE_BIT] = 1'b1;
    cw[WORD_BIT] = 1'b1;
    cw[REPEAT_BIT] = 1'b1;
    cw[SMODE_LSB +: 2] = MODE_FIXED;
    cw[DMODE_LSB +: 2] = MODE_RELOAD;
    cw[START_LSB +: 2] = START_VBLANK;
    cw[15:0] = 16'd2;
    send_word(CMD_CTRL, 2'd3, cw, START_NOW);
    send_word(CMD_EVENT, 2'd0, 32'd0, START_VBLANK);
    send_tick();
    send_tick();
    send_word(CMD_EVENT, 2'd0, 32'd0, START_VBLANK);
    send_tick();
    send_word(CMD_CTRL, 2'd3, 32'd0, START_NOW);
    send_tick();

    // Channel 1: count zero means a full narrow block; rewrite flags mid-block, then stop.
    cw = 32'd0;
    cw[ENABLE_BIT] = 1'b1;
    cw[WORD_BIT] = 1'b1;
    cw[SMODE_LSB +: 2] = MODE_DEC;
    send_word(CMD_CTRL, 2'd1, cw, START_NOW);
    send_tick();
    cw = 32'd0;
    cw[ENABLE_BIT] = 1'b1;
    cw[SMODE_LSB +: 2] = MODE_RELOAD;
    cw[DMODE_LSB +: 2] = MODE_FIXED;
    cw[START_LSB +: 2] = START_HBLANK;
    cw[15:0] = 16'd5;
    send_word(CMD_CTRL, 2'd1, cw, START_NOW);
    send_tick();
    send_word(CMD_CTRL, 2'd1, 32'd0, START_NOW);

    // Channel 2: repeat on an immediate channel still clears enable at block end.
    cw = 32'd0;
    cw[ENABLE_BIT] = 1'b1;
    cw[REPEAT_BIT] = 1'b1;
    cw[15:0] = 16'd1;
    send_word(CMD_CTRL, 2'd2, cw, START_NOW);
    send_tick();

    wait_for_results();

    // Random part: mostly well-formed blocks, the rest noise and broken blocks.
    while (words_sent < ITEMS_TARGET) begin
      if (words_sent >= CALM_FROM) calm = 1'b1;
      if (words_sent >= next_pause) begin
        wait_for_results();
        next_pause = next_pause + PAUSE_EVERY;
      end
      pick = $urandom_range(99, 0);
      if (pick < 55) run_block(2'($urandom()));
      else if (pick < 80) run_noise();
      else run_broken(2'($urandom()));
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.close();

    $display("Drove %0d command words; checked %0d transfers across %0d finished blocks",
             words_sent, sb.checked, sb.blocks_done);
    $display("including %0d repeat reloads, with random stalls on both sides.", sb.reloads);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
